### rtl/drt_pkg.sv
`default_nettype none

package drt_pkg;

    // table geometry
    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // field widths
    localparam int ADDR_W  = 16;
    localparam int TYPE_W  = 8;
    localparam int CFG_W   = 8;
    localparam int SALT_W  = 32;
    localparam int SLOT_W  = 4;
    localparam int SIDX_W  = 5;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ADDRESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SALT_VALUE    = 1'b1;

    localparam logic [ADDR_W-1:0] START_ADDRESS_RESET = 16'h0001;
    localparam logic [SALT_W-1:0] SALT_VALUE_RESET    = 32'hAABB_CCDD;
    localparam logic [ADDR_W-1:0] FREE_ADDRESS        = 16'h0000;

    // operation codes
    localparam logic [2:0] OP_REGISTER  = 3'd0;
    localparam logic [2:0] OP_UPDATE    = 3'd1;
    localparam logic [2:0] OP_LOOKUP    = 3'd2;
    localparam logic [2:0] OP_REMOVE    = 3'd3;
    localparam logic [2:0] OP_READ_SLOT = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    // slot index reported when no entry is found
    localparam logic [SIDX_W-1:0] NO_SLOT = SIDX_W'(ENTRIES);

    // request payload
    typedef struct packed {
        logic [2:0]        operation;
        logic [ADDR_W-1:0] address;
        logic [TYPE_W-1:0] device_type;
        logic [CFG_W-1:0]  config_bits;
        logic [SLOT_W-1:0] slot;
    } t_req;

    // result payload
    typedef struct packed {
        logic [1:0]        status;
        logic [SIDX_W-1:0] slot_index;
        logic [ADDR_W-1:0] entry_address;
        logic [TYPE_W-1:0] entry_type;
        logic [CFG_W-1:0]  entry_config;
        logic [SALT_W-1:0] entry_salt;
    } t_rsp;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic search;
        logic select;
        logic apply;
    } t_cmd;

endpackage

`default_nettype wire

### rtl/drt_ctrl.sv
`default_nettype none

module drt_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    output drt_pkg::t_cmd      o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_SELECT,
        S_APPLY
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   r_search;
    logic   r_select;
    logic   r_apply;
    logic   w_load;

    // a request is taken only while idle
    assign w_load = start && !r_busy;

    // state and registered step strobes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_busy   <= 1'b0;
            r_search <= 1'b0;
            r_select <= 1'b0;
            r_apply  <= 1'b0;
        end else begin
            r_search <= 1'b0;
            r_select <= 1'b0;
            r_apply  <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_load) begin
                        r_state  <= S_SEARCH;
                        r_busy   <= 1'b1;
                        r_search <= 1'b1;
                    end
                end
                S_SEARCH: begin
                    r_state  <= S_SELECT;
                    r_select <= 1'b1;
                end
                S_SELECT: begin
                    r_state <= S_APPLY;
                    r_apply <= 1'b1;
                end
                S_APPLY: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    assign busy          = r_busy;
    assign o_cmd.load    = w_load;
    assign o_cmd.search  = r_search;
    assign o_cmd.select  = r_select;
    assign o_cmd.apply   = r_apply;

endmodule

`default_nettype wire

### rtl/drt_datapath.sv
`default_nettype none

module drt_datapath (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire drt_pkg::t_cmd                     i_cmd,
    input  wire drt_pkg::t_req                     i_req,
    input  wire logic                              i_cfg_we,
    input  wire logic [drt_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [drt_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    output logic                                   o_done,
    output drt_pkg::t_rsp                          o_rsp
);

    // configuration registers
    logic [drt_pkg::ADDR_W-1:0] r_start_addr;
    logic [drt_pkg::SALT_W-1:0] r_salt;

    // entry stores
    logic [drt_pkg::ADDR_W-1:0] r_addr_mem [drt_pkg::ENTRIES];
    logic [drt_pkg::TYPE_W-1:0] r_type_mem [drt_pkg::ENTRIES];
    logic [drt_pkg::CFG_W-1:0]  r_cfg_mem  [drt_pkg::ENTRIES];
    logic [drt_pkg::SALT_W-1:0] r_salt_mem [drt_pkg::ENTRIES];

    // request and search state
    drt_pkg::t_req                r_req;
    logic [drt_pkg::ENTRIES-1:0]  r_hit;
    logic [drt_pkg::ENTRIES-1:0]  n_hit;
    logic [drt_pkg::IDX_W-1:0]    r_idx;
    logic [drt_pkg::IDX_W-1:0]    n_idx;
    logic                         r_found;
    logic                         n_found;

    // result register
    drt_pkg::t_rsp r_rsp;
    drt_pkg::t_rsp n_rsp;
    logic          r_done;

    // entry update
    logic                       w_wr;
    logic [drt_pkg::ADDR_W-1:0] w_wr_addr;
    logic [drt_pkg::TYPE_W-1:0] w_wr_type;
    logic [drt_pkg::CFG_W-1:0]  w_wr_cfg;
    logic [drt_pkg::SALT_W-1:0] w_wr_salt;

    // current entry contents at the selected index
    logic [drt_pkg::ADDR_W-1:0] w_old_addr;
    logic [drt_pkg::TYPE_W-1:0] w_old_type;
    logic [drt_pkg::CFG_W-1:0]  w_old_cfg;
    logic [drt_pkg::SALT_W-1:0] w_old_salt;

    assign w_old_addr = r_addr_mem[r_idx];
    assign w_old_type = r_type_mem[r_idx];
    assign w_old_cfg  = r_cfg_mem[r_idx];
    assign w_old_salt = r_salt_mem[r_idx];

    // per entry compare: free slot for register, address match otherwise
    always_comb begin
        for (int i = 0; i < drt_pkg::ENTRIES; i++) begin
            if (r_req.operation == drt_pkg::OP_REGISTER) begin
                n_hit[i] = (r_addr_mem[i] == drt_pkg::FREE_ADDRESS);
            end else begin
                n_hit[i] = (r_req.address != drt_pkg::FREE_ADDRESS)
                        && (r_addr_mem[i] == r_req.address);
            end
        end
    end

    // lowest hit wins; read slot takes its index directly
    always_comb begin
        n_found = 1'b0;
        n_idx   = '0;
        for (int i = drt_pkg::ENTRIES - 1; i >= 0; i--) begin
            if (r_hit[i]) begin
                n_found = 1'b1;
                n_idx   = drt_pkg::IDX_W'(i);
            end
        end
        priority if (r_req.operation == drt_pkg::OP_READ_SLOT) begin
            n_found = (32'(r_req.slot) < 32'(drt_pkg::ENTRIES));
            n_idx   = drt_pkg::IDX_W'(r_req.slot);
        end else if (r_req.operation != drt_pkg::OP_REGISTER
                  && r_req.operation != drt_pkg::OP_UPDATE
                  && r_req.operation != drt_pkg::OP_LOOKUP
                  && r_req.operation != drt_pkg::OP_REMOVE) begin
            n_found = 1'b0;
        end else begin
            n_found = n_found;
        end
    end

    // operation on the selected entry and the result it reports
    always_comb begin
        w_wr       = 1'b0;
        w_wr_addr  = w_old_addr;
        w_wr_type  = w_old_type;
        w_wr_cfg   = w_old_cfg;
        w_wr_salt  = w_old_salt;

        n_rsp.status        = drt_pkg::ST_OK;
        n_rsp.slot_index    = drt_pkg::SIDX_W'(r_idx);
        n_rsp.entry_address = w_old_addr;
        n_rsp.entry_type    = w_old_type;
        n_rsp.entry_config  = w_old_cfg;
        n_rsp.entry_salt    = w_old_salt;

        if (r_found) begin
            unique case (r_req.operation)
                drt_pkg::OP_REGISTER: begin
                    w_wr      = 1'b1;
                    w_wr_addr = (r_req.address != drt_pkg::FREE_ADDRESS) ? r_req.address
                              : r_start_addr + drt_pkg::ADDR_W'(r_idx);
                    w_wr_type = r_req.device_type;
                    w_wr_cfg  = '0;
                    w_wr_salt = r_salt;
                    n_rsp.entry_address = w_wr_addr;
                    n_rsp.entry_type    = w_wr_type;
                    n_rsp.entry_config  = w_wr_cfg;
                    n_rsp.entry_salt    = w_wr_salt;
                end
                drt_pkg::OP_UPDATE: begin
                    w_wr     = 1'b1;
                    w_wr_cfg = w_old_cfg | r_req.config_bits;
                    n_rsp.entry_config = w_wr_cfg;
                end
                drt_pkg::OP_REMOVE: begin
                    // report the contents as they were, then clear
                    w_wr      = 1'b1;
                    w_wr_addr = drt_pkg::FREE_ADDRESS;
                    w_wr_type = '0;
                    w_wr_cfg  = '0;
                    w_wr_salt = '0;
                end
                default: begin
                    w_wr = 1'b0;
                end
            endcase
        end else begin
            n_rsp.status        = (r_req.operation == drt_pkg::OP_REGISTER)
                                ? drt_pkg::ST_FULL : drt_pkg::ST_NOT_FOUND;
            n_rsp.slot_index    = drt_pkg::NO_SLOT;
            n_rsp.entry_address = '0;
            n_rsp.entry_type    = '0;
            n_rsp.entry_config  = '0;
            n_rsp.entry_salt    = '0;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_addr <= drt_pkg::START_ADDRESS_RESET;
            r_salt       <= drt_pkg::SALT_VALUE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                drt_pkg::CFG_START_ADDRESS: r_start_addr <= i_cfg_wdata[drt_pkg::ADDR_W-1:0];
                drt_pkg::CFG_SALT_VALUE:    r_salt       <= i_cfg_wdata[drt_pkg::SALT_W-1:0];
                default:                    r_salt       <= r_salt;
            endcase
        end
    end

    // entry stores, cleared at reset so every slot starts free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < drt_pkg::ENTRIES; i++) begin
                r_addr_mem[i] <= drt_pkg::FREE_ADDRESS;
                r_type_mem[i] <= '0;
                r_cfg_mem[i]  <= '0;
                r_salt_mem[i] <= '0;
            end
        end else if (i_cmd.apply && r_found && w_wr) begin
            r_addr_mem[r_idx] <= w_wr_addr;
            r_type_mem[r_idx] <= w_wr_type;
            r_cfg_mem[r_idx]  <= w_wr_cfg;
            r_salt_mem[r_idx] <= w_wr_salt;
        end
    end

    // request capture and search pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.search) begin
            r_hit <= n_hit;
        end
        if (i_cmd.select) begin
            r_idx   <= n_idx;
            r_found <= n_found;
        end
        if (i_cmd.apply) begin
            r_rsp <= n_rsp;
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.apply;
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

`default_nettype wire

### rtl/device_registry_table.sv
`default_nettype none

// Device registry table: a fixed table of device entries searched by address.
// Each request (register, update config, lookup, remove, read slot) passes
// through three steps before the next one can be accepted: the first
// compares every entry's address in parallel, the second picks the lowest
// matching entry, the third reads and rewrites that entry and registers the
// result. The result is shown for exactly one cycle with o_done high and
// cannot be held off; busy drops in that same cycle, so the next request may
// be taken while the result is on the ports. The table is cleared by reset.
// Configuration writes are meant for times when no request is in flight.

module device_registry_table (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire drt_pkg::t_req                     i_req,
    output logic                                   o_done,
    output drt_pkg::t_rsp                          o_rsp,
    input  wire logic                              i_cfg_we,
    input  wire logic [drt_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [drt_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    drt_pkg::t_cmd w_cmd;

    // sequencing of each request
    drt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (w_cmd)
    );

    // table storage, search and result
    drt_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_done      (o_done),
        .o_rsp       (o_rsp)
    );

endmodule

`default_nettype wire
